// ===== rtl/prrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle region colorer package
// Shared types and codes: input word, result word, rectangle table entry,
// operation codes and configuration register addresses.
// ----------------------------------------------------------------------------
package prrc_pkg;

    // Operation codes carried in the op field of an input word.
    localparam logic [1:0] OP_LOAD_RECT  = 2'd0;
    localparam logic [1:0] OP_LOAD_COLOR = 2'd1;
    localparam logic [1:0] OP_QUERY      = 2'd2;

    // Configuration port: two registers, accessed as 32-bit words at byte addresses 0 and 4.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_COLORS_ADDR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RECTS_ADDR  = 3'd4;

    // One input word: a load or a query.
    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         slot;
        logic signed [31:0] min_x;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_z;
        logic [3:0]         owner_color;
        logic [31:0]        rgba_word;
        logic signed [31:0] point_x;
        logic signed [31:0] point_z;
    } item_word_t;

    // One result word, produced for each query.
    typedef struct packed {
        logic       hit;
        logic [3:0] matched_color;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } result_word_t;

    // One rectangle table entry as stored in memory.
    typedef struct packed {
        logic signed [31:0] low_x;
        logic signed [31:0] low_z;
        logic signed [31:0] high_x;
        logic signed [31:0] high_z;
        logic [3:0]         owner;
    } rect_entry_t;

endpackage

// ===== rtl/prrc_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle region colorer stream channel
// Valid/ready channel that moves one word per handshake.
// ----------------------------------------------------------------------------
interface prrc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/priority_rectangle_region_colorer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority rectangle region colorer core
// Finds the lowest color slot whose rectangles contain a query point and
// returns that slot with its RGBA color.
// ----------------------------------------------------------------------------
// A load is written in idle; a new word is accepted in the following cycle.
// A query scans the rectangle memory one entry per cycle over nrect entries,
// nrect being rects_in_use capped at RECT_ENTRIES, then passes through the drain,
// color-read and result states; with nrect zero it goes straight to the color read.
// A result still held by the receiver makes the next query wait in the result state.
// Reset clears control state and configuration registers; the tables are undefined until written.
module priority_rectangle_region_colorer_core #(
    parameter int COLOR_SLOTS  = 16,
    parameter int RECT_ENTRIES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [prrc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    prrc_stream_if.sink                     item,
    prrc_stream_if.source                   result
);
    import prrc_pkg::*;

    localparam int AW  = (RECT_ENTRIES > 1) ? $clog2(RECT_ENTRIES) : 1;
    localparam int NW  = $clog2(RECT_ENTRIES + 1);
    localparam int CAW = (COLOR_SLOTS > 1) ? $clog2(COLOR_SLOTS) : 1;
    localparam int NCW = $clog2(COLOR_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COLOR,
        ST_RESULT
    } state_t;

    // Configuration registers.
    logic [4:0] colors_reg;
    logic [6:0] rects_reg;

    // Control and datapath registers.
    state_t             state_reg, state_next;
    logic [NW-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [NW-1:0]      nrect_reg, nrect_next;
    logic [NCW-1:0]     ncol_reg, ncol_next;
    logic signed [31:0] px_reg, px_next;
    logic signed [31:0] pz_reg, pz_next;
    logic               found_reg, found_next;
    logic [3:0]         best_reg, best_next;
    logic               rd_valid_reg, rd_valid_next;
    result_word_t       out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    // Memories and their registered read data.
    rect_entry_t rect_mem [RECT_ENTRIES];
    logic [31:0] color_mem [COLOR_SLOTS];
    rect_entry_t rect_rd_reg;
    logic [31:0] color_rd_reg;

    item_word_t  in_word;
    logic        in_fire;
    logic        rect_we;
    logic        color_we;
    logic        rect_re;
    logic        color_re;
    logic        cfg_we;
    logic        entry_match;
    rect_entry_t new_entry;

    assign in_word = item.payload;
    assign item.ready = (state_reg == ST_IDLE);
    assign in_fire = item.valid && item.ready;

    // Configuration port: writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_reg <= '0;
            rects_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (paddr == REG_COLORS_ADDR)
            begin
                colors_reg <= pwdata[4:0];
            end
            else if (paddr == REG_RECTS_ADDR)
            begin
                rects_reg <= pwdata[6:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_COLORS_ADDR)
        begin
            prdata = {27'd0, colors_reg};
        end
        else if (paddr == REG_RECTS_ADDR)
        begin
            prdata = {25'd0, rects_reg};
        end
    end

    // Table writes happen only in idle, reads only during a query.
    assign rect_we  = in_fire && (in_word.op == OP_LOAD_RECT)
                      && ({26'd0, in_word.slot} < 32'(RECT_ENTRIES));
    assign color_we = in_fire && (in_word.op == OP_LOAD_COLOR)
                      && ({26'd0, in_word.slot} < 32'(COLOR_SLOTS));
    assign rect_re  = (state_reg == ST_SCAN);
    assign color_re = (state_reg == ST_COLOR);

    assign new_entry.low_x  = in_word.min_x;
    assign new_entry.low_z  = in_word.min_z;
    assign new_entry.high_x = in_word.max_x;
    assign new_entry.high_z = in_word.max_z;
    assign new_entry.owner  = in_word.owner_color;

    // Rectangle memory: one port, registered read data.
    always_ff @(posedge clk)
    begin
        if (rect_we)
        begin
            rect_mem[AW'(in_word.slot)] <= new_entry;
        end
        else if (rect_re)
        begin
            rect_rd_reg <= rect_mem[scan_cnt_reg[AW-1:0]];
        end
    end

    // Color memory: one port, registered read data.
    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[CAW'(in_word.slot)] <= in_word.rgba_word;
        end
        else if (color_re)
        begin
            color_rd_reg <= color_mem[CAW'(best_reg)];
        end
    end

    // Containment test on the entry read in the previous cycle.
    assign entry_match = rd_valid_reg
                         && (px_reg >= rect_rd_reg.low_x) && (px_reg <= rect_rd_reg.high_x)
                         && (pz_reg >= rect_rd_reg.low_z) && (pz_reg <= rect_rd_reg.high_z)
                         && ({28'd0, rect_rd_reg.owner} < 32'(ncol_reg));

    // Next-state logic of the query sequencer.
    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        nrect_next     = nrect_reg;
        ncol_next      = ncol_reg;
        px_next        = px_reg;
        pz_next        = pz_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        rd_valid_next  = rect_re;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;

        // Keep the lowest matching owner seen so far.
        if (entry_match && (!found_reg || (rect_rd_reg.owner < best_reg)))
        begin
            found_next = 1'b1;
            best_next  = rect_rd_reg.owner;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_word.op == OP_QUERY))
                begin
                    px_next       = in_word.point_x;
                    pz_next       = in_word.point_z;
                    found_next    = 1'b0;
                    best_next     = '0;
                    scan_cnt_next = '0;
                    if ({25'd0, rects_reg} > 32'(RECT_ENTRIES))
                    begin
                        nrect_next = NW'(RECT_ENTRIES);
                    end
                    else
                    begin
                        nrect_next = NW'(rects_reg);
                    end
                    if ({27'd0, colors_reg} > 32'(COLOR_SLOTS))
                    begin
                        ncol_next = NCW'(COLOR_SLOTS);
                    end
                    else
                    begin
                        ncol_next = NCW'(colors_reg);
                    end
                    if (rects_reg == 7'd0)
                    begin
                        state_next = ST_COLOR;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == nrect_reg - NW'(1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + NW'(1);
                end
            end
            ST_DRAIN:
            begin
                // The last entry is compared in this cycle.
                state_next = ST_COLOR;
            end
            ST_COLOR:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (found_reg)
                    begin
                        out_next.hit           = 1'b1;
                        out_next.matched_color = best_reg;
                        out_next.red           = color_rd_reg[31:24];
                        out_next.green         = color_rd_reg[23:16];
                        out_next.blue          = color_rd_reg[15:8];
                        out_next.alpha         = color_rd_reg[7:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            nrect_reg     <= '0;
            ncol_reg      <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            nrect_reg     <= nrect_next;
            ncol_reg      <= ncol_next;
            found_reg     <= found_next;
            best_reg      <= best_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        pz_reg  <= pz_next;
        out_reg <= out_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

`ifndef ASSERT_OFF
    // A new result word only comes out of the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result word raised outside the result state");

    // The scan address never reaches the entry count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg < nrect_reg))
        else $error("scan address beyond rectangles in use");

    // A miss carries zero slot and zero color.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.hit) |->
            (out_reg.matched_color == 4'd0 && out_reg.red == 8'd0
             && out_reg.green == 8'd0 && out_reg.blue == 8'd0 && out_reg.alpha == 8'd0))
        else $error("miss with nonzero payload");

    // A hit names a slot below the number of colors in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.hit) |-> ({28'd0, out_reg.matched_color} < 32'(ncol_reg)))
        else $error("hit on a color slot not in use");

    // Every read issued in the scan is compared in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> rd_valid_reg)
        else $error("scan read without compare");
`endif

endmodule

// ===== tb/tb_priority_rectangle_region_colorer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority rectangle region colorer core testbench
// Loads rectangles and colors, then checks every query word against a
// predictor that scans its own copy of the tables. Both stream sides idle in
// random bursts, and the result side once holds off long enough to stall input.
// Register settings run from empty tables to the saturated maximum.
// ----------------------------------------------------------------------------
module tb_priority_rectangle_region_colorer_core;
    import prrc_pkg::*;

    localparam int COLOR_SLOTS  = 16;
    localparam int RECT_ENTRIES = 64;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int PHASE_WORDS  = 120;
    localparam int PHASE_COUNT  = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

    // Clock, reset and configuration port.
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Stream channels and the testbench side of their handshakes.
    prrc_stream_if #(.payload_t(item_word_t))   word_ch ();
    prrc_stream_if #(.payload_t(result_word_t)) result_ch ();

    logic       word_valid   = 1'b0;
    item_word_t word_payload = '0;
    logic       result_ready = 1'b0;

    assign word_ch.valid     = word_valid;
    assign word_ch.payload   = word_payload;
    assign result_ch.ready   = result_ready;

    priority_rectangle_region_colorer_core #(
        .COLOR_SLOTS  (COLOR_SLOTS),
        .RECT_ENTRIES (RECT_ENTRIES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (word_ch),
        .result  (result_ch)
    );

    // Shadow copy of the block's tables and registers.
    logic signed [31:0] span_lo_x [RECT_ENTRIES];
    logic signed [31:0] span_lo_z [RECT_ENTRIES];
    logic signed [31:0] span_hi_x [RECT_ENTRIES];
    logic signed [31:0] span_hi_z [RECT_ENTRIES];
    logic [3:0]         span_owner [RECT_ENTRIES];
    logic [31:0]        palette [COLOR_SLOTS];
    logic [4:0]         colors_active = '0;
    logic [6:0]         rects_active  = '0;

    item_word_t   words_to_send [$];
    result_word_t awaited_results [$];

    // Run bookkeeping.
    int  error_count    = 0;
    int  words_accepted = 0;
    int  queries_seen   = 0;
    int  hits_seen      = 0;
    int  settings_used  = 0;
    int  cycle_count    = 0;
    int  word_gap       = 0;
    int  hold_left      = 0;
    logic word_taken      = 1'b0;
    logic long_hold_go    = 1'b0;
    logic long_hold_done  = 1'b0;
    logic calm_finish     = 1'b0;
    result_word_t want_word;
    result_word_t got_word;

    int colors_plan [PHASE_COUNT] = '{16, 31, 0, 16, 1, -1, 16, -1, 8, 16};
    int rects_plan  [PHASE_COUNT] = '{64, 127, 64, 0, 1, -1, 64, -1, 63, 64};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Lowest color slot that owns an active rectangle containing the point.
    function automatic result_word_t locate_color(logic signed [31:0] px,
                                                  logic signed [31:0] pz);
        result_word_t res;
        int ncol;
        int nrect;
        int best;
        logic [31:0] rgba;
        res   = '0;
        ncol  = (colors_active > COLOR_SLOTS) ? COLOR_SLOTS : int'(colors_active);
        nrect = (rects_active > RECT_ENTRIES) ? RECT_ENTRIES : int'(rects_active);
        best  = ncol;
        for (int r = 0; r < nrect; r++)
        begin
            if (int'(span_owner[r]) < best &&
                px >= span_lo_x[r] && px <= span_hi_x[r] &&
                pz >= span_lo_z[r] && pz <= span_hi_z[r])
                best = int'(span_owner[r]);
        end
        if (best < ncol)
        begin
            rgba              = palette[best];
            res.hit           = 1'b1;
            res.matched_color = 4'(best);
            res.red           = rgba[31:24];
            res.green         = rgba[23:16];
            res.blue          = rgba[15:8];
            res.alpha         = rgba[7:0];
        end
        return res;
    endfunction

    // Update the shadow tables for an accepted word, or queue its answer.
    function automatic void absorb_word(item_word_t w);
        case (w.op)
            OP_LOAD_RECT:
            begin
                if (w.slot < RECT_ENTRIES)
                begin
                    span_lo_x[w.slot]  = w.min_x;
                    span_lo_z[w.slot]  = w.min_z;
                    span_hi_x[w.slot]  = w.max_x;
                    span_hi_z[w.slot]  = w.max_z;
                    span_owner[w.slot] = w.owner_color;
                end
            end
            OP_LOAD_COLOR:
            begin
                if (w.slot < COLOR_SLOTS)
                    palette[w.slot] = w.rgba_word;
            end
            OP_QUERY:
            begin
                awaited_results.push_back(locate_color(w.point_x, w.point_z));
                queries_seen++;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Every field random, so that fields a word does not use still toggle.
    function automatic item_word_t noise_word();
        item_word_t w;
        w.op          = 2'($urandom);
        w.slot        = 6'($urandom);
        w.min_x       = $urandom();
        w.min_z       = $urandom();
        w.max_x       = $urandom();
        w.max_z       = $urandom();
        w.owner_color = 4'($urandom);
        w.rgba_word   = $urandom();
        w.point_x     = $urandom();
        w.point_z     = $urandom();
        return w;
    endfunction

    // Mostly a small window so that points and rectangles meet often.
    function automatic logic signed [31:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return 32'(int'($urandom_range(0, 128)) - 64);
        if (pick < 17)
        begin
            case ($urandom_range(0, 5))
                0: return COORD_MIN;
                1: return COORD_MIN + 1;
                2: return COORD_MAX;
                3: return COORD_MAX - 1;
                4: return -1;
                default: return 0;
            endcase
        end
        return $urandom();
    endfunction

    // Bounds on one axis; now and then left unordered, giving an empty span.
    function automatic void rand_span(output logic signed [31:0] lo,
                                      output logic signed [31:0] hi);
        logic signed [31:0] a;
        logic signed [31:0] b;
        a = rand_coord();
        b = rand_coord();
        if ($urandom_range(0, 9) != 0 && a > b)
        begin
            lo = b;
            hi = a;
        end
        else
        begin
            lo = a;
            hi = b;
        end
    endfunction

    function automatic item_word_t random_rect(logic [5:0] slot);
        item_word_t w;
        w             = noise_word();
        w.op          = OP_LOAD_RECT;
        w.slot        = slot;
        rand_span(w.min_x, w.max_x);
        rand_span(w.min_z, w.max_z);
        return w;
    endfunction

    function automatic item_word_t rect_word(logic [5:0] slot,
                                             logic signed [31:0] lx, logic signed [31:0] lz,
                                             logic signed [31:0] hx, logic signed [31:0] hz,
                                             logic [3:0] owner);
        item_word_t w;
        w             = noise_word();
        w.op          = OP_LOAD_RECT;
        w.slot        = slot;
        w.min_x       = lx;
        w.min_z       = lz;
        w.max_x       = hx;
        w.max_z       = hz;
        w.owner_color = owner;
        return w;
    endfunction

    function automatic item_word_t color_word(logic [5:0] slot, logic [31:0] rgba);
        item_word_t w;
        w           = noise_word();
        w.op        = OP_LOAD_COLOR;
        w.slot      = slot;
        w.rgba_word = rgba;
        return w;
    endfunction

    function automatic item_word_t query_word(logic signed [31:0] x, logic signed [31:0] z);
        item_word_t w;
        w         = noise_word();
        w.op      = OP_QUERY;
        w.point_x = x;
        w.point_z = z;
        return w;
    endfunction

    // Random traffic: queries and rectangle loads dominate.
    function automatic item_word_t random_word();
        item_word_t w;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            w = query_word(rand_coord(), rand_coord());
        else if (pick < 85)
            w = random_rect(6'($urandom_range(0, 63)));
        else if (pick < 97)
        begin
            if ($urandom_range(0, 4) == 0)
                w = color_word(6'($urandom_range(COLOR_SLOTS, 63)), $urandom());
            else
                w = color_word(6'($urandom_range(0, COLOR_SLOTS - 1)), $urandom());
        end
        else
        begin
            w    = noise_word();
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    // One configuration transfer: setup cycle, then access cycle.
    task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write both registers, mirror them, and read them back.
    task automatic set_regions(input int colors, input int rects);
        logic [31:0] rd;
        cfg_access(1'b1, REG_COLORS_ADDR, 32'(colors), rd);
        cfg_access(1'b1, REG_RECTS_ADDR, 32'(rects), rd);
        colors_active = 5'(colors);
        rects_active  = 7'(rects);
        settings_used++;
        cfg_access(1'b0, REG_COLORS_ADDR, '0, rd);
        if (rd != 32'(colors_active))
        begin
            $display("[%0t] colors_in_use readback: expected %0d, got %0d",
                     $time, colors_active, rd);
            error_count++;
        end
        cfg_access(1'b0, REG_RECTS_ADDR, '0, rd);
        if (rd != 32'(rects_active))
        begin
            $display("[%0t] rects_in_use readback: expected %0d, got %0d",
                     $time, rects_active, rd);
            error_count++;
        end
    endtask

    task automatic queue_word(input item_word_t w);
        words_to_send.push_back(w);
    endtask

    // Wait for every word and result, then for a full scan to finish.
    task automatic drain();
        while (words_to_send.size() != 0 || word_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (RECT_ENTRIES + 8) @(posedge clk);
    endtask

    task automatic compare_field(input string tag, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $display("[%0t] result %s: expected %0h, got %0h", $time, tag, want, got);
            error_count++;
        end
    endtask

    // Word driver: a new word goes out once the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!word_valid || word_taken))
        begin
            if (word_gap > 0)
            begin
                word_valid <= 1'b0;
                word_gap = word_gap - 1;
            end
            else if (words_to_send.size() > 0)
            begin
                word_payload <= words_to_send.pop_front();
                word_valid   <= 1'b1;
                if (!calm_finish && $urandom_range(0, 11) == 0)
                    word_gap = $urandom_range(1, 13);
            end
            else
                word_valid <= 1'b0;
        end
    end

    // Accepted words feed the predictor.
    always @(posedge clk)
    begin
        word_taken <= word_valid && word_ch.ready;
        if (rst_n && word_valid && word_ch.ready)
        begin
            absorb_word(word_payload);
            words_accepted++;
        end
    end

    // Result ready: random stall bursts, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (long_hold_go && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            result_ready <= 1'b0;
        end
        else if (!calm_finish && $urandom_range(0, 9) == 0)
        begin
            hold_left = $urandom_range(0, 12);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // Result checker against the oldest expected answer.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ready)
        begin
            got_word = result_ch.payload;
            if (awaited_results.size() == 0)
            begin
                $display("[%0t] unexpected result: expected none, got %0h", $time, got_word);
                error_count++;
            end
            else
            begin
                want_word = awaited_results.pop_front();
                compare_field("hit", 8'(want_word.hit), 8'(got_word.hit));
                compare_field("matched_color", 8'(want_word.matched_color),
                              8'(got_word.matched_color));
                compare_field("red", want_word.red, got_word.red);
                compare_field("green", want_word.green, got_word.green);
                compare_field("blue", want_word.blue, got_word.blue);
                compare_field("alpha", want_word.alpha, got_word.alpha);
                if (got_word.hit)
                    hits_seen++;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        int colors;
        int rects;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers still at reset: nothing can match, and stray loads are dropped.
        queue_word(query_word(0, 0));
        begin
            item_word_t w;
            w    = noise_word();
            w.op = OP_UNUSED;
            queue_word(w);
        end
        queue_word(color_word(6'd16, 32'hA5A5_5A5A));
        queue_word(color_word(6'd63, 32'h5A5A_A5A5));
        queue_word(color_word(6'd0, 32'hFFFF_FFFF));
        queue_word(color_word(6'd1, 32'h0000_0000));
        queue_word(color_word(6'd2, 32'h1234_5678));
        queue_word(color_word(6'd3, 32'h80FF_01FE));
        queue_word(rect_word(6'd0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 4'd3));
        queue_word(rect_word(6'd1, 5, -5, 5, -5, 4'd1));
        queue_word(rect_word(6'd2, 10, COORD_MIN, -10, COORD_MAX, 4'd0));
        queue_word(rect_word(6'd3, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 4'd2));
        queue_word(rect_word(6'd4, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 4'd15));
        queue_word(rect_word(6'd5, -100, -100, 100, 100, 4'd1));
        drain();

        // Priority among overlapping rectangles, inclusive edges, empty span.
        set_regions(4, 6);
        queue_word(query_word(5, -5));
        queue_word(query_word(COORD_MIN, COORD_MAX));
        queue_word(query_word(COORD_MAX, COORD_MIN));
        queue_word(query_word(11, 0));
        queue_word(query_word(0, 0));
        queue_word(query_word(100, -100));
        queue_word(query_word(101, 0));
        drain();

        // The only active rectangle belongs to a slot that is not in use.
        set_regions(3, 1);
        queue_word(query_word(0, 0));
        drain();

        // Fill both tables so that any later setting reads written entries.
        for (int s = 0; s < RECT_ENTRIES; s++)
            queue_word(random_rect(6'(s)));
        for (int s = 0; s < COLOR_SLOTS; s++)
            queue_word(color_word(6'(s), $urandom()));
        drain();

        // Random phases over a range of register settings.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            colors = (colors_plan[p] < 0) ? $urandom_range(0, COLOR_SLOTS) : colors_plan[p];
            rects  = (rects_plan[p] < 0) ? $urandom_range(0, RECT_ENTRIES) : rects_plan[p];
            set_regions(colors, rects);
            if (p == PHASE_COUNT - 1)
                calm_finish = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++)
                queue_word(random_word());
            if (p == 0)
                long_hold_go = 1'b1;
            drain();
        end

        $display("Run covered %0d words, %0d of them queries with %0d hits, over %0d settings.",
                 words_accepted, queries_seen, hits_seen, settings_used);
        $display("%s %0d-cycle output stall.",
                 "It included saturated registers, dropped loads, the spare op code and a",
                 LONG_HOLD);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
